// ----- hdl/dq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared constants, operation and status codes, and the ring index helper.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Fixed interface widths.
    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    // Result tdata: popped_value, length, is_empty, padded to whole bytes.
    localparam int OUT_BITS    = VALUE_W + CNT_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Request from the controller to the element memory.
    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [IDX_W-1:0]      addr;
        logic [DATA_WIDTH-1:0] wdata;
    } mem_req_t;

    // Result fields known at accept time; the popped word follows from memory.
    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] length;
        logic             pop_ok;
    } meta_t;

    // Wraps a sum below twice the capacity back into the ring.
    function automatic logic [IDX_W-1:0] ring_wrap(input logic [CNT_W:0] sum);
        logic [CNT_W:0] cap;
        cap = (CNT_W + 1)'(CAPACITY);
        if (sum >= cap)
        begin
            ring_wrap = IDX_W'(sum - cap);
        end
        else
        begin
            ring_wrap = IDX_W'(sum);
        end
    endfunction

endpackage
`default_nettype wire

// ----- hdl/double_ended_queue_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque in a ring buffer with stream-style input and result ports.
// ----------------------------------------------------------------------------
// Each input item is one operation (push front, push back, pop front, pop
// back) and produces exactly one result item carrying a status, the popped
// word, the queue length after the operation and an empty flag. The words
// live in a single-port memory of CAPACITY entries with a registered read;
// the controller keeps the front index and the element count in flip-flops.
// A result appears in the cycle after its item is accepted, the cycle taken by
// the memory read, and the block takes one item per cycle for as long as
// the result side keeps taking items. A pop on an empty queue and a push on
// a full queue leave the queue unchanged and are reported in the status.
// The memory contents are not cleared at reset; only entries written by a
// push are ever read, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module double_ended_queue_top
    import dq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [31:0] push_value
    input  wire logic [VALUE_W-1:0]     s_axis_tdata,
    // [1:0] operation
    input  wire logic [OP_W-1:0]        s_axis_tuser,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [31:0] popped_value, then length, then is_empty, zero padding on top
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic      [STAT_W-1:0]      m_axis_tuser
);

    logic                  accept;
    mem_req_t              mem_req;
    meta_t                 meta;
    logic [DATA_WIDTH-1:0] rd_data;

    // Output stage: valid flag plus the result fields captured at accept.
    logic                  out_valid_reg;
    meta_t                 out_meta_reg;
    logic [VALUE_W-1:0]    popped;

    // The output stage frees up in the same cycle its item is taken, so an
    // item per cycle flows while the result side is ready.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    dq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .op      (op_t'(s_axis_tuser)),
        .value   (s_axis_tdata),
        .mem_req (mem_req),
        .meta    (meta)
    );

    // The read register only loads on an accepted pop, so a stalled result
    // keeps its popped word.
    dq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_meta_reg <= meta;
        end
    end

    assign popped = out_meta_reg.pop_ok ? VALUE_W'(rd_data) : '0;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_meta_reg.status;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}},
                            (out_meta_reg.length == '0),
                            out_meta_reg.length,
                            popped};

    // A dropped push or a failed pop never touches the memory.
    a_no_access_on_reject: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && meta.status != ST_OK) |-> (!mem_req.we && !mem_req.re)
    ) else $error("memory accessed by a rejected operation");

    // A successful pop reads the memory and its result follows in the next cycle.
    a_pop_reads_memory: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && meta.pop_ok) |-> (mem_req.re && !mem_req.we)
    ) else $error("successful pop without a memory read");

    a_pop_result_next: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && meta.pop_ok) |=> (m_axis_tvalid && m_axis_tuser == ST_OK)
    ) else $error("pop result not presented after accept");

    // Only a successful pop carries a nonzero word.
    a_popped_zero_on_fail: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata[VALUE_W-1:0] == '0)
    ) else $error("nonzero popped word on a failed operation");

    // The length never goes past the capacity.
    a_length_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_meta_reg.length <= CNT_W'(CAPACITY))
    ) else $error("queue length above capacity");

endmodule
`default_nettype wire

// ----- hdl/dq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Element memory
// Single-port synchronous RAM with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- hdl/dq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Queue controller
// Holds the front index and element count and turns each operation into
// at most one memory access plus the status and length of its result.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire op_t                op,
    input  wire logic [VALUE_W-1:0] value,
    output mem_req_t                mem_req,
    output meta_t                   meta
);

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             full, empty;
    logic [CNT_W:0]   back_sum, last_sum, inc_sum;
    logic [IDX_W-1:0] front_dec;

    always_comb
    begin
        full      = (count_reg == CNT_W'(CAPACITY));
        empty     = (count_reg == '0);
        back_sum  = (CNT_W + 1)'(front_reg) + (CNT_W + 1)'(count_reg);
        last_sum  = back_sum - (CNT_W + 1)'(1);
        inc_sum   = (CNT_W + 1)'(front_reg) + (CNT_W + 1)'(1);
        front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1)
                                      : front_reg - IDX_W'(1);

        front_next    = front_reg;
        count_next    = count_reg;
        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.addr  = front_reg;
        mem_req.wdata = DATA_WIDTH'(value);
        meta.status   = ST_OK;
        meta.pop_ok   = 1'b0;

        unique case (op)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    meta.status = ST_FULL;
                end
                else
                begin
                    front_next   = front_dec;
                    count_next   = count_reg + CNT_W'(1);
                    mem_req.we   = accept;
                    mem_req.addr = front_dec;
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    meta.status = ST_FULL;
                end
                else
                begin
                    count_next   = count_reg + CNT_W'(1);
                    mem_req.we   = accept;
                    mem_req.addr = ring_wrap(back_sum);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    meta.status = ST_EMPTY;
                end
                else
                begin
                    front_next   = ring_wrap(inc_sum);
                    count_next   = count_reg - CNT_W'(1);
                    mem_req.re   = accept;
                    mem_req.addr = front_reg;
                    meta.pop_ok  = 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    meta.status = ST_EMPTY;
                end
                else
                begin
                    count_next   = count_reg - CNT_W'(1);
                    mem_req.re   = accept;
                    mem_req.addr = ring_wrap(last_sum);
                    meta.pop_ok  = 1'b1;
                end
            end
            default:
            begin
                meta.status = ST_OK;
            end
        endcase

        meta.length = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire
